### rtl/keyed_md5_xor_transform_unit_macros.svh
// Assertion macros for the keyed MD5 XOR transform unit.
`ifndef KEYED_MD5_XOR_TRANSFORM_UNIT_MACROS_SVH
`define KEYED_MD5_XOR_TRANSFORM_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define KMX_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define KMX_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/kmx_pkg.sv
// Shared types, constants and MD5 round functions for the keyed MD5 XOR transform.
package kmx_pkg;
  localparam int MaxBytes = 32;
  localparam int LenW = 6;
  // One MD5 compression is split into this many stages, each running RoundsPerStage rounds.
  localparam int RoundsPerStage = 4;
  localparam int CompStages = 64 / RoundsPerStage;
  localparam int StageW = $clog2(CompStages);
  localparam int OffMod = 23;

  localparam logic [31:0] InitInner [4] = '{32'hF3FA75B2, 32'h4674956E, 32'hDF65E04E,
                                            32'h6C779AAF};
  localparam logic [31:0] InitOuter [4] = '{32'h942AAA39, 32'hBB8F3AE9, 32'hF10FD6A7,
                                            32'h177FEE2C};

  localparam logic [31:0] SineK [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE, 32'hF57C0FAF, 32'h4787C62A,
    32'hA8304613, 32'hFD469501, 32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821, 32'hF61E2562, 32'hC040B340,
    32'h265E5A51, 32'hE9B6C7AA, 32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED, 32'hA9E3E905, 32'hFCEFA3F8,
    32'h676F02D9, 32'h8D2A4C8A, 32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70, 32'h289B7EC6, 32'hEAA127FA,
    32'hD4EF3085, 32'h04881D05, 32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039, 32'h655B59C3, 32'h8F0CCC92,
    32'hFFEFF47D, 32'h85845DD1, 32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391};

  localparam int RotAmt [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  typedef logic [31:0] word_t;
  typedef word_t [15:0] msg_t;
  typedef word_t [3:0] chain_t;

  function automatic word_t rotl(input word_t v, input logic [4:0] s);
    logic [63:0] dbl;
    begin
      dbl = {v, v} << s;
      rotl = dbl[63:32];
    end
  endfunction

  // Byte value modulo OffMod by conditional subtraction of OffMod*8, *4, *2, *1.
  function automatic logic [7:0] offset_mod(input logic [7:0] v);
    logic [8:0] x;
    begin
      x = {1'b0, v};
      for (int k = 3; k >= 0; k--)
        if (x >= 9'(OffMod << k)) x = x - 9'(OffMod << k);
      offset_mod = x[7:0];
    end
  endfunction

  // One MD5 round i on state (a,b,c,d) packed as chain_t {d,c,b,a}.
  function automatic chain_t md5_round(input chain_t st, input msg_t m, input logic [5:0] i);
    word_t a, b, c, d, f, t;
    logic [3:0] g;
    logic [1:0] r;
    chain_t o;
    begin
      a = st[0]; b = st[1]; c = st[2]; d = st[3];
      r = i[5:4];
      case (r)
        2'd0: begin f = (b & c) | (~b & d); g = i[3:0]; end
        2'd1: begin f = (d & b) | (~d & c); g = 4'(5 * i + 1); end
        2'd2: begin f = b ^ c ^ d; g = 4'(3 * i + 5); end
        default: begin f = c ^ (b | ~d); g = 4'(7 * i); end
      endcase
      t = a + f + SineK[i] + m[g];
      o[0] = d;
      o[1] = b + rotl(t, 5'(RotAmt[{r, i[1:0]}]));
      o[2] = b;
      o[3] = c;
      md5_round = o;
    end
  endfunction

  typedef struct packed {
    logic [MaxBytes*8-1:0] data;
    logic [LenW-1:0]       len;
    logic                  bad;
  } side_t;
endpackage

### rtl/kmx_comp_stage.sv
// One register stage of the MD5 pipeline: RoundsPerStage rounds for both halves plus sideband.
module kmx_comp_stage import kmx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [StageW-1:0] stage_idx,
  input  logic              in_valid,
  input  chain_t            in_st [2],
  input  msg_t              in_msg [2],
  input  chain_t            in_iv [2],
  input  side_t             in_side,
  output logic              out_valid,
  output chain_t            out_st [2],
  output msg_t              out_msg [2],
  output chain_t            out_iv [2],
  output side_t             out_side
);
  chain_t st_next [2];

  // stage_idx is tied to a constant per instance
  always_comb begin
    for (int h = 0; h < 2; h++) begin
      st_next[h] = in_st[h];
      for (int k = 0; k < RoundsPerStage; k++)
        st_next[h] = md5_round(st_next[h], in_msg[h], 6'(stage_idx * RoundsPerStage + k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_st   <= st_next;
      out_msg  <= in_msg;
      out_iv   <= in_iv;
      out_side <= in_side;
    end
  end
endmodule

### rtl/kmx_compress.sv
// Full MD5 compression pipeline (16 stages) with chaining add at the end.
module kmx_compress import kmx_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_valid,
  input  msg_t   in_msg [2],
  input  chain_t in_iv [2],
  input  side_t  in_side,
  output logic   out_valid,
  output chain_t out_dig [2],
  output side_t  out_side
);
  logic   v  [CompStages+1];
  chain_t st [CompStages+1][2];
  msg_t   ms [CompStages+1][2];
  chain_t iv [CompStages+1][2];
  side_t  sd [CompStages+1];

  assign v[0]  = in_valid;
  assign st[0] = in_iv;
  assign ms[0] = in_msg;
  assign iv[0] = in_iv;
  assign sd[0] = in_side;

  for (genvar s = 0; s < CompStages; s++) begin : g_stage
    kmx_comp_stage u_stage (
      .clk(clk), .rst(rst), .adv(adv), .stage_idx(StageW'(s)),
      .in_valid(v[s]), .in_st(st[s]), .in_msg(ms[s]), .in_iv(iv[s]), .in_side(sd[s]),
      .out_valid(v[s+1]), .out_st(st[s+1]), .out_msg(ms[s+1]), .out_iv(iv[s+1]),
      .out_side(sd[s+1])
    );
  end

  always_comb begin
    for (int h = 0; h < 2; h++)
      for (int j = 0; j < 4; j++)
        out_dig[h][j] = iv[CompStages][h][j] + st[CompStages][h][j];
  end
  assign out_valid = v[CompStages];
  assign out_side  = sd[CompStages];
endmodule

### rtl/keyed_md5_xor_transform_unit.sv
// Top level: message build, inner and outer MD5 pipelines, keystream XOR and output register.
// Fully pipelined: one item per cycle unless backpressure stalls, through the input register,
// 16 round stages per MD5 compression, one register between compressions and one output
// register. Each stage runs four MD5 rounds for both halves; backpressure stalls the
// whole pipeline at once, so ready is low only while a valid result waits at the output.
`include "keyed_md5_xor_transform_unit_macros.svh"
module keyed_md5_xor_transform_unit import kmx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_word_0,
  input  logic [63:0] data_word_1,
  input  logic [63:0] data_word_2,
  input  logic [63:0] data_word_3,
  input  logic [5:0]  data_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_word_0,
  output logic [63:0] result_word_1,
  output logic [63:0] result_word_2,
  output logic [63:0] result_word_3,
  output logic        status
);
  logic [31:0] uid;
  logic adv;
  logic s0_valid;
  side_t s0_side;
  logic [7:0] s0_off [2];
  msg_t   in_msg [2];
  chain_t in_iv [2];
  logic   i_valid;
  chain_t i_dig [2];
  side_t  i_side;
  logic   m_valid;
  chain_t m_dig [2];
  side_t  m_side;
  msg_t   o_msg [2];
  chain_t o_iv [2];
  logic   o_valid;
  chain_t o_dig [2];
  side_t  o_side;
  logic [MaxBytes*8-1:0] raw, masked, res_next;
  logic bad;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      uid <= '0;
    end else if (cfg_valid) begin
      uid <= cfg_data;
    end
  end

  // Whole pipeline advances unless the output holds a result not yet taken.
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  assign raw = {data_word_3, data_word_2, data_word_1, data_word_0};
  assign bad = (data_length == '0) || (data_length > LenW'(MaxBytes));
  always_comb begin
    for (int i = 0; i < MaxBytes; i++)
      masked[i*8 +: 8] = (LenW'(i) < data_length) ? raw[i*8 +: 8] : 8'h00;
  end

  // Stage 0: latch data and compute placement offsets.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side.data <= bad ? raw : masked;
      s0_side.len  <= data_length;
      s0_side.bad  <= bad;
      s0_off[0]    <= offset_mod(masked[7:0]);
      s0_off[1]    <= offset_mod(masked[135:128]);
    end
  end

  // Inner message: data shifted into zeroed block, padding byte and bit count.
  always_comb begin
    logic [511:0] blk;
    for (int h = 0; h < 2; h++) begin
      blk = 512'(s0_side.data) << (s0_off[h] * 8);
      blk[55*8 +: 8] = 8'h80;
      for (int w = 0; w < 16; w++) in_msg[h][w] = blk[w*32 +: 32];
      in_msg[h][14] = 32'd952;
      in_msg[h][15] = 32'd0;
      for (int j = 0; j < 4; j++) in_iv[h][j] = InitInner[j] ^ uid;
    end
  end

  kmx_compress u_inner (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(s0_valid), .in_msg(in_msg), .in_iv(in_iv),
    .in_side(s0_side), .out_valid(i_valid), .out_dig(i_dig), .out_side(i_side)
  );

  // Register between compressions keeps the chaining add off the first outer stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= i_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_dig  <= i_dig;
      m_side <= i_side;
    end
  end

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      o_msg[h] = '0;
      for (int j = 0; j < 4; j++) begin
        o_msg[h][j] = m_dig[h][j];
        o_iv[h][j]  = InitOuter[j] ^ uid;
      end
      o_msg[h][4]  = 32'h80;
      o_msg[h][14] = 32'd640;
    end
  end

  kmx_compress u_outer (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(m_valid), .in_msg(o_msg), .in_iv(o_iv),
    .in_side(m_side), .out_valid(o_valid), .out_dig(o_dig), .out_side(o_side)
  );

  // Data beyond length is already zero, so masking the key keeps it zero.
  always_comb begin
    logic [255:0] key;
    key = {o_dig[1][3], o_dig[1][2], o_dig[1][1], o_dig[1][0],
           o_dig[0][3], o_dig[0][2], o_dig[0][1], o_dig[0][0]};
    for (int i = 0; i < MaxBytes; i++)
      res_next[i*8 +: 8] = o_side.data[i*8 +: 8] ^
        ((LenW'(i) < o_side.len) ? key[i*8 +: 8] : 8'h00);
    if (o_side.bad) res_next = o_side.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= o_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      {result_word_3, result_word_2, result_word_1, result_word_0} <= res_next;
      status <= o_side.bad;
    end
  end

  `KMX_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result_word_0), "result changed while stalled")
  `KMX_ASSERT_IMP(a_ready, clk, rst, !in_ready, out_valid, "input stalled without a waiting result")
  `KMX_ASSERT_NXT(a_status, clk, rst, adv && o_valid && o_side.bad, status, "bad length lost its status")
endmodule

### sim/keyed_md5_xor_transform_unit_tb.sv
// Self-checking testbench for the keyed MD5 XOR transform unit.
module keyed_md5_xor_transform_unit_tb;
  import kmx_pkg::*;

  localparam int PipeLatency = 35;
  localparam int StallLimit = 20000;
  localparam int RandomItems = 700;
  localparam int HoldCycles = 300;

  typedef struct {
    logic [63:0] w [4];
    logic [5:0]  len;
  } xform_in_t;

  typedef struct {
    logic [63:0] w [4];
    logic        status;
  } xform_out_t;

  typedef struct {
    xform_in_t  item;
    logic       known;
    xform_out_t result;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] data_word_0 = '0, data_word_1 = '0, data_word_2 = '0, data_word_3 = '0;
  logic [5:0]  data_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] result_word_0, result_word_1, result_word_2, result_word_3;
  logic        status;

  keyed_md5_xor_transform_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_word_0(data_word_0), .data_word_1(data_word_1),
    .data_word_2(data_word_2), .data_word_3(data_word_3), .data_length(data_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_word_0(result_word_0), .result_word_1(result_word_1),
    .result_word_2(result_word_2), .result_word_3(result_word_3), .status(status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the key register
  logic [31:0] uid_shadow = '0;
  xform_out_t  pending_results [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 1'b0;

  localparam logic [31:0] KInner [4] = '{32'hF3FA75B2, 32'h4674956E, 32'hDF65E04E,
                                         32'h6C779AAF};
  localparam logic [31:0] KOuter [4] = '{32'h942AAA39, 32'hBB8F3AE9, 32'hF10FD6A7,
                                         32'h177FEE2C};
  localparam int Shift [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  function automatic void md5_compress(ref logic [31:0] h [4], input logic [31:0] m [16]);
    logic [31:0] a, b, c, d, f, t, nb;
    int g, r;
    a = h[0]; b = h[1]; c = h[2]; d = h[3];
    for (int i = 0; i < 64; i++) begin
      r = i / 16;
      case (r)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      t = a + f + SineK[i] + m[g];
      nb = b + ((t << Shift[r * 4 + i % 4]) | (t >> (32 - Shift[r * 4 + i % 4])));
      a = d; d = c; c = b; b = nb;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d;
  endfunction

  function automatic xform_out_t keyed_transform(input xform_in_t x, input logic [31:0] key);
    xform_out_t  o;
    logic [7:0]  data [32];
    logic [7:0]  stream [32];
    logic [7:0]  blk [64];
    logic [31:0] msg [16];
    logic [31:0] hin [4];
    logic [31:0] hout [4];
    int          off;
    if (x.len == 0 || x.len > MaxBytes) begin
      o.w = x.w;
      o.status = 1'b1;
      return o;
    end
    for (int i = 0; i < 32; i++) data[i] = (i < x.len) ? x.w[i / 8][(i % 8) * 8 +: 8] : 8'h00;
    for (int h = 0; h < 2; h++) begin
      off = data[h * 16] % OffMod;
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      for (int i = 0; i < x.len; i++) blk[off + i] = data[i];
      blk[55] = 8'h80;
      for (int i = 0; i < 16; i++)
        msg[i] = {blk[4 * i + 3], blk[4 * i + 2], blk[4 * i + 1], blk[4 * i]};
      msg[14] = 32'd952;
      msg[15] = 32'd0;
      for (int i = 0; i < 4; i++) begin
        hin[i] = KInner[i] ^ key;
        hout[i] = KOuter[i] ^ key;
      end
      md5_compress(hin, msg);
      for (int i = 0; i < 16; i++) msg[i] = '0;
      for (int i = 0; i < 4; i++) msg[i] = hin[i];
      msg[4] = 32'h80;
      msg[14] = 32'd640;
      md5_compress(hout, msg);
      for (int i = 0; i < 16; i++) stream[h * 16 + i] = hout[i / 4][(i % 4) * 8 +: 8];
    end
    for (int k = 0; k < 4; k++) o.w[k] = '0;
    for (int i = 0; i < x.len; i++) o.w[i / 8][(i % 8) * 8 +: 8] = data[i] ^ stream[i];
    o.status = 1'b0;
    return o;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    xform_out_t got, want;
    if (!rst && out_valid && out_ready) begin
      got.w = '{result_word_0, result_word_1, result_word_2, result_word_3};
      got.status = status;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", status);
      end else begin
        want = pending_results.pop_front();
        if (got.w != want.w || got.status != want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h %h st %0d, got %h %h %h %h st %0d",
                     want.w[0], want.w[1], want.w[2], want.w[3], want.status,
                     got.w[0], got.w[1], got.w[2], got.w[3], got.status);
        end
      end
    end
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // valid stays high between back-to-back items; it drops only for idle gaps and drains
  task automatic send_item(input xform_in_t x, input bit known, input xform_out_t exp_res);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_word_0 <= x.w[0];
    data_word_1 <= x.w[1];
    data_word_2 <= x.w[2];
    data_word_3 <= x.w[3];
    data_length <= x.len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(known ? exp_res : keyed_transform(x, uid_shadow));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PipeLatency + 5) @(posedge clk);
  endtask

  task automatic write_uid(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    uid_shadow = v;
  endtask

  function automatic xform_in_t rand_item(input bit legal);
    xform_in_t x;
    for (int k = 0; k < 4; k++) x.w[k] = {$urandom, $urandom};
    case ($urandom_range(3))
      0: x.len = legal ? 6'($urandom_range(1, 16)) : 6'($urandom_range(33, 63));
      1: x.len = legal ? 6'($urandom_range(17, 32)) : 6'd0;
      default: x.len = legal ? 6'($urandom_range(1, 32)) : 6'($urandom_range(0, 63));
    endcase
    return x;
  endfunction

  stim_row_t  directed [$];
  xform_out_t nil_res;
  xform_in_t  x;
  logic [31:0] uid_list [5] = '{32'h0, 32'hFFFFFFFF, 32'hA5A5_5A5A, 32'h1, 32'h8000_0000};
  int          idle_plan [4][2] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{33, 33}};

  function automatic stim_row_t row(input logic [63:0] a, b, c, d, input logic [5:0] n);
    stim_row_t r;
    r.item.w = '{a, b, c, d};
    r.item.len = n;
    r.known = (n == 0 || n > MaxBytes);
    r.result.w = r.item.w;
    r.result.status = 1'b1;
    return r;
  endfunction

  initial begin
    nil_res.w = '{64'h0, 64'h0, 64'h0, 64'h0};
    nil_res.status = 1'b0;
    // bad lengths echo data, short data, offset extremes, all-ones, full length
    directed.push_back(row('1, '1, '1, '1, 6'd0));
    directed.push_back(row(64'h0123456789ABCDEF, 64'h1, 64'h2, 64'h3, 6'd33));
    directed.push_back(row('1, '0, '1, '0, 6'd63));
    directed.push_back(row('0, '0, '0, '0, 6'd1));
    directed.push_back(row('1, '1, '1, '1, 6'd1));
    directed.push_back(row('1, '1, '1, '1, 6'd16));
    directed.push_back(row('1, '1, '1, '1, 6'd17));
    directed.push_back(row('1, '1, '1, '1, 6'd32));
    directed.push_back(row('0, '0, '0, '0, 6'd32));
    directed.push_back(row(64'h16, '0, 64'h16, '0, 6'd32));
    directed.push_back(row(64'h17, '0, 64'h2D, '0, 6'd32));
    directed.push_back(row(64'hFE, 64'h5555, 64'hFF, 64'hAAAA, 6'd24));
    directed.push_back(row(64'hDEADBEEF, 64'hCAFEF00D, 64'h12, 64'h34, 6'd8));
    directed.push_back(row(64'h8000000000000000, '1, '0, '1, 6'd15));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_item(directed[i].item, directed[i].known, directed[i].result);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_uid(uid_list[p]);
      send_idle_pct = idle_plan[p % 4][0];
      recv_stall_pct = idle_plan[p % 4][1];
      if (p == 2) fork
        begin
          hold_off = 1'b1;
          repeat (HoldCycles) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
      for (int i = 0; i < RandomItems / 5; i++) begin
        x = rand_item($urandom_range(9) != 0);
        send_item(x, 1'b0, nil_res);
      end
      // sender pause until everything is back, then idle for config write
      drain();
    end

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/kmx_pkg.sv
rtl/kmx_comp_stage.sv
rtl/kmx_compress.sv
rtl/keyed_md5_xor_transform_unit.sv
sim/keyed_md5_xor_transform_unit_tb.sv
